[rtl/core/nmp_pkg.sv]
// ----------------------------------------------------------------------------
// Normalized motion profile package
// Shared widths, register indexes, phase codes and pipeline item types.
// ----------------------------------------------------------------------------
package nmp_pkg;

  // Time sample width and the widths that follow from it.
  localparam int TIME_BITS  = 16;
  localparam int BLEND_BITS = TIME_BITS - 1;
  localparam int SQ_W       = 2 * TIME_BITS;
  localparam int CUBE_W     = 3 * TIME_BITS;
  // The divisor is twice the denominator.
  localparam int DEN_W      = CUBE_W + 1;
  // Every quotient fits in 32 bits.
  localparam int Q_W        = 32;
  localparam int X_W        = DEN_W + Q_W;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_MODE     = 2'd0,
    REG_DURATION = 2'd1,
    REG_BLEND    = 2'd2
  } cfg_reg_e;

  // Profile modes.
  localparam logic MODE_TRAP  = 1'b0;
  localparam logic MODE_CUBIC = 1'b1;

  // Segments of the trapezoidal profile.
  typedef enum logic [1:0] {
    PH_ACCEL  = 2'd0,
    PH_CRUISE = 2'd1,
    PH_DECEL  = 2'd2
  } phase_e;

  // Current register settings.
  typedef struct packed {
    logic                  mode;
    logic [TIME_BITS-1:0]  dur;
    logic [BLEND_BITS-1:0] blend;
  } cfg_t;

  // One lane of the restoring divider: partial remainder, dividend bits
  // still to be shifted in (which fill up with quotient bits), divisor.
  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [Q_W-1:0]   low;
    logic [DEN_W-1:0] dvs;
  } lane_t;

  // Item in the divider pipeline: position, velocity, acceleration lanes.
  typedef struct packed {
    lane_t [2:0] lane;
    logic        neg;
    logic        bad;
  } div_item_t;

endpackage

[rtl/core/nmp_front.sv]
// ----------------------------------------------------------------------------
// Normalized motion profile front end
// Four register stages that clamp the time sample, form the products and
// build dividend and divisor for each of the three result lanes.
// ----------------------------------------------------------------------------
module nmp_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [nmp_pkg::TIME_BITS-1:0]  time_now_i,
  input  nmp_pkg::cfg_t                  cfg_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output nmp_pkg::div_item_t             out_item_o
);

  localparam int TB = nmp_pkg::TIME_BITS;

  typedef struct packed {
    logic            mode;
    logic            bad;
    logic            neg;
    nmp_pkg::phase_e phase;
    logic [TB-1:0]   t;
    logic [TB-1:0]   dur;
    logic [TB-1:0]   tc;
    logic [TB-1:0]   tmt;
    logic [TB-1:0]   tmc;
    logic [TB-1:0]   a2;
    logic [TB+1:0]   c3;
  } s1_t;

  typedef struct packed {
    logic                         mode;
    logic                         bad;
    logic                         neg;
    nmp_pkg::phase_e              phase;
    logic [TB-1:0]                t;
    logic [TB-1:0]                dur;
    logic [TB-1:0]                tc;
    logic [TB-1:0]                tmt;
    logic [TB-1:0]                a2;
    logic [TB+1:0]                c3;
    logic [nmp_pkg::SQ_W-1:0]     tt;
    logic [nmp_pkg::SQ_W-1:0]     ttm;
    logic [nmp_pkg::SQ_W-1:0]     dsq;
    logic [nmp_pkg::SQ_W-1:0]     dd;
    logic [nmp_pkg::SQ_W-1:0]     tct;
    logic [nmp_pkg::SQ_W-1:0]     tcc;
    logic [nmp_pkg::SQ_W-1:0]     uu;
  } s2_t;

  typedef struct packed {
    logic                         mode;
    logic                         bad;
    logic                         neg;
    nmp_pkg::phase_e              phase;
    logic [TB-1:0]                a2;
    logic [TB-1:0]                vnum;
    logic [nmp_pkg::SQ_W:0]       pnum;
    logic [nmp_pkg::SQ_W-1:0]     ttm;
    logic [nmp_pkg::SQ_W-1:0]     dd;
    logic [nmp_pkg::CUBE_W-1:0]   cub;
    logic [nmp_pkg::CUBE_W-1:0]   dcube;
  } s3_t;

  logic v1_q, v2_q, v3_q, v4_q;
  logic go1, go2, go3, go4;
  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  s3_t s3_d, s3_q;
  nmp_pkg::div_item_t s4_d, s4_q;

  // A stage takes a new item when it is empty or its contents move on.
  assign go4 = !v4_q || !out_stall_i;
  assign go3 = !v3_q || go4;
  assign go2 = !v2_q || go3;
  assign go1 = !v1_q || go2;
  assign in_stall_o = !go1;

  // Stage 1: clamp time, differences and phase decisions.
  always_comb begin
    logic [TB-1:0] t;
    logic [TB:0]   t2;
    logic [TB:0]   tc2;
    t   = (time_now_i > cfg_i.dur) ? cfg_i.dur : time_now_i;
    t2  = {t, 1'b0};
    tc2 = {1'b0, cfg_i.blend, 1'b0};
    s1_d.mode = cfg_i.mode;
    s1_d.t    = t;
    s1_d.dur  = cfg_i.dur;
    s1_d.tc   = TB'(cfg_i.blend);
    s1_d.tmt  = cfg_i.dur - t;
    s1_d.tmc  = cfg_i.dur - TB'(cfg_i.blend);
    s1_d.c3   = (TB+2)'(3 * (TB+2)'(cfg_i.dur)) - (TB+2)'(t2);
    if ({1'b0, cfg_i.dur} >= t2) begin
      s1_d.a2 = TB'({1'b0, cfg_i.dur} - t2);
    end else begin
      s1_d.a2 = TB'(t2 - {1'b0, cfg_i.dur});
    end
    if (t <= TB'(cfg_i.blend)) begin
      s1_d.phase = nmp_pkg::PH_ACCEL;
    end else if (t <= cfg_i.dur - TB'(cfg_i.blend)) begin
      s1_d.phase = nmp_pkg::PH_CRUISE;
    end else begin
      s1_d.phase = nmp_pkg::PH_DECEL;
    end
    s1_d.bad = (cfg_i.dur == '0) ||
               ((cfg_i.mode == nmp_pkg::MODE_TRAP) &&
                ((cfg_i.blend == '0) || (tc2 > {1'b0, cfg_i.dur})));
    if (cfg_i.mode == nmp_pkg::MODE_CUBIC) begin
      s1_d.neg = t2 > {1'b0, cfg_i.dur};
    end else begin
      s1_d.neg = s1_d.phase == nmp_pkg::PH_DECEL;
    end
  end

  // Stage 2: the square products.
  always_comb begin
    s2_d.mode  = s1_q.mode;
    s2_d.bad   = s1_q.bad;
    s2_d.neg   = s1_q.neg;
    s2_d.phase = s1_q.phase;
    s2_d.t     = s1_q.t;
    s2_d.dur   = s1_q.dur;
    s2_d.tc    = s1_q.tc;
    s2_d.tmt   = s1_q.tmt;
    s2_d.a2    = s1_q.a2;
    s2_d.c3    = s1_q.c3;
    s2_d.tt    = s1_q.t * s1_q.t;
    s2_d.ttm   = s1_q.t * s1_q.tmt;
    s2_d.dsq   = s1_q.dur * s1_q.dur;
    s2_d.dd    = s1_q.tc * s1_q.tmc;
    s2_d.tct   = s1_q.tc * s1_q.t;
    s2_d.tcc   = s1_q.tc * s1_q.tc;
    s2_d.uu    = s1_q.tmt * s1_q.tmt;
  end

  // Stage 3: cubes and the trapezoidal numerators.
  always_comb begin
    logic [nmp_pkg::CUBE_W+1:0] cub_full;
    logic [nmp_pkg::CUBE_W-1:0] dcube_full;
    cub_full   = s2_q.tt * s2_q.c3;
    dcube_full = nmp_pkg::CUBE_W'(s2_q.dsq) * nmp_pkg::CUBE_W'(s2_q.dur);
    s3_d.mode  = s2_q.mode;
    s3_d.bad   = s2_q.bad;
    s3_d.neg   = s2_q.neg;
    s3_d.phase = s2_q.phase;
    s3_d.a2    = s2_q.a2;
    s3_d.ttm   = s2_q.ttm;
    s3_d.dd    = s2_q.dd;
    s3_d.cub   = cub_full[nmp_pkg::CUBE_W-1:0];
    s3_d.dcube = dcube_full;
    case (s2_q.phase)
      nmp_pkg::PH_ACCEL: begin
        s3_d.pnum = {1'b0, s2_q.tt};
        s3_d.vnum = s2_q.t;
      end
      nmp_pkg::PH_CRUISE: begin
        s3_d.pnum = {s2_q.tct, 1'b0} - {1'b0, s2_q.tcc};
        s3_d.vnum = s2_q.tc;
      end
      default: begin
        s3_d.pnum = {s2_q.dd, 1'b0} - {1'b0, s2_q.uu};
        s3_d.vnum = s2_q.tmt;
      end
    endcase
  end

  // Stage 4: dividend 2*K*N + den and divisor 2*den for each lane.
  always_comb begin
    logic [nmp_pkg::CUBE_W-1:0] den;
    logic [nmp_pkg::X_W-1:0]    xp, xv, xa, dx;
    den = '0;
    xp  = '0;
    xv  = '0;
    xa  = '0;
    if (s3_q.bad) begin
      den = nmp_pkg::CUBE_W'(1);
    end else if (s3_q.mode == nmp_pkg::MODE_CUBIC) begin
      den = s3_q.dcube;
      xp  = nmp_pkg::X_W'(s3_q.cub) << 32;
      xv  = (nmp_pkg::X_W'(s3_q.ttm) << 33) + (nmp_pkg::X_W'(s3_q.ttm) << 32);
      xa  = (nmp_pkg::X_W'(s3_q.a2) << 31) + (nmp_pkg::X_W'(s3_q.a2) << 30);
    end else begin
      den = nmp_pkg::CUBE_W'(s3_q.dd);
      xp  = nmp_pkg::X_W'(s3_q.pnum) << 31;
      xv  = nmp_pkg::X_W'(s3_q.vnum) << 31;
      if (s3_q.phase != nmp_pkg::PH_CRUISE) begin
        xa = nmp_pkg::X_W'(1) << 29;
      end
    end
    dx = nmp_pkg::X_W'(den);
    xp = xp + dx;
    xv = xv + dx;
    xa = xa + dx;
    s4_d.neg = s3_q.neg && !s3_q.bad;
    s4_d.bad = s3_q.bad;
    s4_d.lane[0].rem = xp[nmp_pkg::X_W-1:nmp_pkg::Q_W];
    s4_d.lane[0].low = xp[nmp_pkg::Q_W-1:0];
    s4_d.lane[1].rem = xv[nmp_pkg::X_W-1:nmp_pkg::Q_W];
    s4_d.lane[1].low = xv[nmp_pkg::Q_W-1:0];
    s4_d.lane[2].rem = xa[nmp_pkg::X_W-1:nmp_pkg::Q_W];
    s4_d.lane[2].low = xa[nmp_pkg::Q_W-1:0];
    s4_d.lane[0].dvs = {den, 1'b0};
    s4_d.lane[1].dvs = {den, 1'b0};
    s4_d.lane[2].dvs = {den, 1'b0};
  end

  // Valid bits travel with the payload registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (go1) v1_q <= in_valid_i;
      if (go2) v2_q <= v1_q;
      if (go3) v3_q <= v2_q;
      if (go4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go1 && in_valid_i) s1_q <= s1_d;
    if (go2 && v1_q) s2_q <= s2_d;
    if (go3 && v2_q) s3_q <= s3_d;
    if (go4 && v3_q) s4_q <= s4_d;
  end

  assign out_valid_o = v4_q;
  assign out_item_o  = s4_q;

endmodule

[rtl/core/nmp_div_stage.sv]
// ----------------------------------------------------------------------------
// Normalized motion profile divider stage
// One restoring division step for each of the three lanes, registered.
// ----------------------------------------------------------------------------
module nmp_div_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  nmp_pkg::div_item_t in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output nmp_pkg::div_item_t out_item_o
);

  logic               valid_q;
  logic               go;
  nmp_pkg::div_item_t item_d, item_q;

  assign go         = !valid_q || !out_stall_i;
  assign in_stall_o = !go;

  // Shift in the next dividend bit, subtract the divisor where it fits,
  // and shift the quotient bit into the bottom of the low word.
  always_comb begin
    logic [nmp_pkg::DEN_W:0] rs;
    logic                    fits;
    item_d = in_item_i;
    for (int k = 0; k < 3; k++) begin
      rs   = {in_item_i.lane[k].rem, in_item_i.lane[k].low[nmp_pkg::Q_W-1]};
      fits = rs >= {1'b0, in_item_i.lane[k].dvs};
      if (fits) begin
        item_d.lane[k].rem = nmp_pkg::DEN_W'(rs - {1'b0, in_item_i.lane[k].dvs});
      end else begin
        item_d.lane[k].rem = nmp_pkg::DEN_W'(rs);
      end
      item_d.lane[k].low = {in_item_i.lane[k].low[nmp_pkg::Q_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (go) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && in_valid_i) item_q <= item_d;
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

[rtl/core/normalized_motion_profile.sv]
// ----------------------------------------------------------------------------
// Normalized motion profile
// Position, velocity and acceleration of a trapezoidal or cubic profile.
// ----------------------------------------------------------------------------
// Usage: present a time sample on time_now_i with in_valid_i; a transfer
// happens on a clock edge where in_valid_i is high and in_stall_o is low.
// Each transfer yields one result on the output channel, moved by a
// transfer where out_valid_o is high and out_stall_i is low.
// Four front-end stages (clamp, squares, cubes, dividend build) feed one
// 32-stage restoring divider, one quotient bit per stage, with three lanes
// side by side. Throughput is one item per cycle unless the output stalls.
// Each stage holds its own valid bit and only stops when it is full and
// the next stage stalls, so bubbles are squeezed out while the output waits.
// Settings are written through cfg_we_i, cfg_index_i and cfg_data_i; the
// user must write them only while the pipeline is empty, which the block
// does not enforce. Indexes beyond the last register are ignored. Reset
// empties the pipeline and loads trapezoidal mode, duration 1000, blend 250.
// ----------------------------------------------------------------------------
module normalized_motion_profile (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [nmp_pkg::TIME_BITS-1:0] time_now_i,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [nmp_pkg::TIME_BITS-1:0] cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [31:0]                   position_o,
  output logic [31:0]                   velocity_o,
  output logic signed [31:0]            acceleration_o,
  output logic                          bad_setting_o
);

  localparam int STEPS = nmp_pkg::Q_W;

  nmp_pkg::cfg_t      cfg_q;
  nmp_pkg::div_item_t item [STEPS+1];
  logic               valid [STEPS+1];
  logic               stall [STEPS+1];
  logic [31:0]        acc_mag;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode  <= nmp_pkg::MODE_TRAP;
      cfg_q.dur   <= nmp_pkg::TIME_BITS'(1000);
      cfg_q.blend <= nmp_pkg::BLEND_BITS'(250);
    end else if (cfg_we_i) begin
      unique case (nmp_pkg::cfg_reg_e'(cfg_index_i))
        nmp_pkg::REG_MODE:     cfg_q.mode  <= cfg_data_i[0];
        nmp_pkg::REG_DURATION: cfg_q.dur   <= cfg_data_i;
        nmp_pkg::REG_BLEND:    cfg_q.blend <= cfg_data_i[nmp_pkg::BLEND_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Front end: clamp, products and dividend build.
  nmp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .time_now_i  (time_now_i),
    .cfg_i       (cfg_q),
    .out_valid_o (valid[0]),
    .out_stall_i (stall[0]),
    .out_item_o  (item[0])
  );

  // Divider pipeline, one quotient bit per stage.
  for (genvar k = 0; k < STEPS; k++) begin : g_div
    nmp_div_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid[k]),
      .in_stall_o  (stall[k]),
      .in_item_i   (item[k]),
      .out_valid_o (valid[k+1]),
      .out_stall_i (stall[k+1]),
      .out_item_o  (item[k+1])
    );
  end

  // The last divider stage is the output register.
  assign stall[STEPS]  = out_stall_i;
  assign out_valid_o   = valid[STEPS];
  assign position_o    = item[STEPS].lane[0].low;
  assign velocity_o    = item[STEPS].lane[1].low;
  assign acc_mag       = item[STEPS].lane[2].low;
  assign acceleration_o = item[STEPS].neg ? $signed(-acc_mag) : $signed(acc_mag);
  assign bad_setting_o = item[STEPS].bad;

  // An invalid setting gives all-zero results.
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_setting_o |->
      position_o == '0 && velocity_o == '0 && acceleration_o == '0)
    else $error("invalid setting with nonzero result");

  // Position never exceeds 1.0.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> position_o <= 32'h8000_0000)
    else $error("position above 1.0");

  // Velocity never exceeds the bound of its format.
  a_vel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> velocity_o <= 32'h8000_0000)
    else $error("velocity out of range");

  // Acceleration magnitude stays within 1.5 * 2^30.
  a_acc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> acc_mag <= 32'd1610612736)
    else $error("acceleration out of range");

endmodule

[dv/nmp_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Normalized motion profile checker
// Watches the configuration port and both channels. It keeps its own copy
// of the settings, computes the expected profile sample for each input
// transfer and compares every output transfer with the oldest expectation.
// ----------------------------------------------------------------------------
module nmp_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [nmp_pkg::TIME_BITS-1:0] time_now_i,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [nmp_pkg::TIME_BITS-1:0] cfg_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [31:0]                   position_i,
  input  logic [31:0]                   velocity_i,
  input  logic signed [31:0]            acceleration_i,
  input  logic                          bad_setting_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  typedef struct packed {
    logic [31:0]        pos;
    logic [31:0]        vel;
    logic signed [31:0] acc;
    logic               bad;
  } sample_t;

  typedef logic [127:0] wide_t;

  logic                           mode_q;
  logic [nmp_pkg::TIME_BITS-1:0]  dur_q;
  logic [nmp_pkg::BLEND_BITS-1:0] blend_q;
  sample_t                        sample_q[$];
  int                             mismatches;

  assign fail_count_o = mismatches;
  assign pending_o    = sample_q.size();

  // a * b / den rounded to nearest, ties upward.
  function automatic wide_t scaled_quotient(wide_t a, wide_t b, wide_t den);
    return (2 * a * b + den) / (2 * den);
  endfunction

  // Profile sample at one time point under the current settings.
  function automatic sample_t profile_at(logic [nmp_pkg::TIME_BITS-1:0] t_raw);
    sample_t s;
    wide_t   t, tt, tc, d, u, cube;
    s  = '0;
    tt = dur_q;
    tc = blend_q;
    t  = (t_raw > dur_q) ? wide_t'(dur_q) : wide_t'(t_raw);
    if (tt == 0) begin
      s.bad = 1'b1;
    end else if (mode_q == nmp_pkg::MODE_CUBIC) begin
      cube  = tt * tt * tt;
      s.pos = 32'(scaled_quotient(wide_t'(1) << 31, t * t * (3 * tt - 2 * t), cube));
      s.vel = 32'(scaled_quotient(wide_t'(6) << 30, t * (tt - t), cube));
      if (tt >= 2 * t)
        s.acc = 32'(scaled_quotient(wide_t'(6) << 28, tt - 2 * t, cube));
      else
        s.acc = -32'(scaled_quotient(wide_t'(6) << 28, 2 * t - tt, cube));
    end else if (tc == 0 || 2 * tc > tt) begin
      s.bad = 1'b1;
    end else begin
      d = tc * (tt - tc);
      if (t <= tc) begin
        s.pos = 32'(scaled_quotient(wide_t'(1) << 30, t * t, d));
        s.vel = 32'(scaled_quotient(wide_t'(1) << 30, t, d));
        s.acc = 32'(scaled_quotient(wide_t'(1) << 28, 1, d));
      end else if (t <= tt - tc) begin
        s.pos = 32'(scaled_quotient(wide_t'(1) << 30, 2 * tc * t - tc * tc, d));
        s.vel = 32'(scaled_quotient(wide_t'(1) << 30, tc, d));
      end else begin
        u     = tt - t;
        s.pos = 32'(scaled_quotient(wide_t'(1) << 30, 2 * d - u * u, d));
        s.vel = 32'(scaled_quotient(wide_t'(1) << 30, u, d));
        s.acc = -32'(scaled_quotient(wide_t'(1) << 28, 1, d));
      end
    end
    return s;
  endfunction

  // Track settings, queue expectations and compare results at each edge.
  always @(posedge clk_i or negedge rst_ni) begin
    sample_t want;
    if (!rst_ni) begin
      mode_q     <= nmp_pkg::MODE_TRAP;
      dur_q      <= 16'd1000;
      blend_q    <= 15'd250;
      mismatches <= 0;
      sample_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          nmp_pkg::REG_MODE:     mode_q  <= cfg_data_i[0];
          nmp_pkg::REG_DURATION: dur_q   <= cfg_data_i;
          nmp_pkg::REG_BLEND:    blend_q <= cfg_data_i[nmp_pkg::BLEND_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        sample_q = {sample_q, profile_at(time_now_i)};
      if (out_valid_i && !out_stall_i) begin
        if (sample_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result transfer at %0t", $realtime);
          mismatches <= mismatches + 1;
        end else begin
          want = sample_q.pop_front();
          if (want.pos !== position_i || want.vel !== velocity_i ||
              want.acc !== acceleration_i || want.bad !== bad_setting_i) begin
            if (mismatches < 10)
              $display("mismatch at %0t: expected pos %h vel %h acc %h bad %b, got %h %h %h %b",
                       $realtime, want.pos, want.vel, want.acc, want.bad,
                       position_i, velocity_i, acceleration_i, bad_setting_i);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Normalized motion profile testbench
// Drives time samples through several settings of both profile modes,
// including invalid ones, with random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb;

  localparam int         TB_BITS    = nmp_pkg::TIME_BITS;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  logic               in_stall;
  logic [TB_BITS-1:0] time_now;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [TB_BITS-1:0] cfg_data;
  logic               out_valid;
  logic               out_stall;
  logic [31:0]        position;
  logic [31:0]        velocity;
  logic signed [31:0] acceleration;
  logic               bad_setting;
  int                 fail_count;
  int                 pending;
  logic               smooth_flow;
  logic               hold_req;
  logic [TB_BITS-1:0] cur_dur;

  normalized_motion_profile dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .time_now_i(time_now),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .position_o(position), .velocity_o(velocity),
    .acceleration_o(acceleration), .bad_setting_o(bad_setting)
  );

  nmp_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .time_now_i(time_now),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .position_i(position), .velocity_i(velocity),
    .acceleration_i(acceleration), .bad_setting_i(bad_setting),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Gap length: mostly short, now and then long.
  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0)
      return $urandom_range(10, 60);
    return $urandom_range(0, 2);
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int n;
    bit held;
    held      = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !held) begin
        held      = 1'b1;
        out_stall = 1'b1;
        for (n = 0; n < 300; n++)
          @(negedge clk_i);
        out_stall = 1'b0;
      end else if (!smooth_flow && $urandom_range(0, 3) == 0) begin
        out_stall = 1'b1;
        repeat (gap_len() + 1) @(negedge clk_i);
        out_stall = 1'b0;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("normalized_motion_profile verification failed");
    $finish;
  end

  // Called at a falling edge; returns at a falling edge after the transfer.
  task automatic send_time(input logic [TB_BITS-1:0] t);
    int n;
    time_now = t;
    in_valid = 1'b1;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
    n = smooth_flow ? 0 : ($urandom_range(0, 2) == 0 ? gap_len() : 0);
    if (n > 0) begin
      in_valid = 1'b0;
      time_now = TB_BITS'($urandom);
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [TB_BITS-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk_i);
    cfg_we    = 1'b0;
  endtask

  // Drain the pipeline before touching the settings.
  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0)
      @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic configure(input logic m, input logic [TB_BITS-1:0] d,
                           input logic [TB_BITS-1:0] b);
    drain();
    write_reg(nmp_pkg::REG_MODE, TB_BITS'(m));
    write_reg(nmp_pkg::REG_DURATION, d);
    write_reg(nmp_pkg::REG_BLEND, b);
    cur_dur = d;
  endtask

  // Random time samples, mostly within the profile, some anywhere.
  task automatic random_times(input int count);
    int i;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 7)
        send_time(TB_BITS'($urandom_range(0, int'(cur_dur) + 2)));
      else
        send_time(TB_BITS'($urandom));
    end
  endtask

  initial begin
    int p;
    logic m;
    logic [TB_BITS-1:0] d, b;
    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    time_now    = '0;
    cfg_we      = 1'b0;
    cfg_index   = nmp_pkg::REG_MODE;
    cfg_data    = '0;
    smooth_flow = 1'b0;
    hold_req    = 1'b0;
    cur_dur     = 16'd1000;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset settings: segment boundaries, end of profile and time past it.
    send_time(16'd0);
    send_time(16'd1);
    send_time(16'd250);
    send_time(16'd251);
    send_time(16'd500);
    send_time(16'd750);
    send_time(16'd751);
    send_time(16'd1000);
    send_time(16'd1001);
    send_time(16'hFFFF);

    // Largest valid trapezoid, blend just under half the duration.
    configure(nmp_pkg::MODE_TRAP, 16'hFFFF, 16'h7FFF);
    send_time(16'd0);
    send_time(16'h7FFF);
    send_time(16'h8000);
    send_time(16'hFFFF);
    // Blend write with the spare top bit set, and a write to no register.
    configure(nmp_pkg::MODE_TRAP, 16'd4, 16'h8002);
    write_reg(REG_UNUSED, 16'h0001);
    send_time(16'd1);
    send_time(16'd2);
    send_time(16'd3);
    // Zero blend, blend over half the duration, zero duration.
    configure(nmp_pkg::MODE_TRAP, 16'd100, 16'd0);
    send_time(16'd50);
    configure(nmp_pkg::MODE_TRAP, 16'd100, 16'd51);
    send_time(16'd50);
    configure(nmp_pkg::MODE_CUBIC, 16'd0, 16'd0);
    send_time(16'd0);
    send_time(16'd7);
    // Cubic extremes.
    configure(nmp_pkg::MODE_CUBIC, 16'd1, 16'd0);
    send_time(16'd0);
    send_time(16'd1);
    configure(nmp_pkg::MODE_CUBIC, 16'hFFFF, 16'h7FFF);
    send_time(16'h7FFF);
    send_time(16'hFFFF);

    // Long hold-off while the sender keeps going, then full-rate flow.
    configure(nmp_pkg::MODE_CUBIC, 16'd3000, 16'd10);
    hold_req = 1'b1;
    random_times(100);
    smooth_flow = 1'b1;
    random_times(80);
    smooth_flow = 1'b0;

    // Random settings, mostly valid and mostly small durations.
    for (p = 0; p < 24; p++) begin
      m = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
        0:       d = TB_BITS'($urandom_range(1, 65535));
        1:       d = TB_BITS'($urandom_range(1, 8));
        default: d = TB_BITS'($urandom_range(2, 2000));
      endcase
      if ($urandom_range(0, 7) == 0)
        b = TB_BITS'($urandom);
      else
        b = TB_BITS'($urandom_range(1, (int'(d) / 2 > 0) ? int'(d) / 2 : 1));
      configure(m, d, b);
      smooth_flow = (p % 6 == 5);
      random_times(48);
    end
    smooth_flow = 1'b0;

    drain();
    if (fail_count == 0 && pending == 0)
      $display("normalized_motion_profile verification clean");
    else
      $display("normalized_motion_profile verification failed");
    $finish;
  end

endmodule
